@@ hw/rtl/sg5_pkg.sv @@
`default_nettype none

package sg5_pkg;

	localparam int PIX_W         = 8;
	localparam int HS_W          = 13;   // horizontal row sum, 17*255 fits
	localparam int ACC_W         = 17;   // vertical total plus rounding bias
	localparam int ROW_W         = 13;
	localparam int WIDTH_REG_W   = 12;
	localparam int HEIGHT_REG_W  = 13;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 13;
	localparam int N_LINES       = 4;
	localparam int N_HTAPS       = 5;

	localparam int MAX_WIDTH_DEF = 2048;
	localparam int MAX_HEIGHT    = 4096;
	localparam int WIDTH_RESET   = 640;
	localparam int HEIGHT_RESET  = 480;

	// (x + 144) / 289 as a multiply by ceil(2^25 / 289); exact for x < 2^17
	localparam int ROUND_BIAS    = 144;
	localparam int RECIP         = 116106;
	localparam int RECIP_W       = 17;
	localparam int RECIP_SHIFT   = 25;
	localparam int PROD_W        = ACC_W + RECIP_W;
	localparam int Q_W           = PROD_W - RECIP_SHIFT;
	localparam int PIX_MAX       = 255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1
	} cfg_reg_t;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_DRAIN = 1'b1
	} op_t;

	typedef struct packed {
		logic             last;
		logic [ACC_W-1:0] acc;
	} acc_item_t;

	typedef struct packed {
		logic             last;
		logic [PIX_W-1:0] pix;
	} result_t;

endpackage

`default_nettype wire

@@ hw/rtl/sg5_line_cell.sv @@
`default_nettype none

module sg5_line_cell #(
	parameter int DEPTH = sg5_pkg::MAX_WIDTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [AW-1:0]            rd_addr,
	output logic [sg5_pkg::HS_W-1:0] rd_data,
	input  logic                     wr_en,
	input  logic [AW-1:0]            wr_addr,
	input  logic [sg5_pkg::HS_W-1:0] wr_data
);
	import sg5_pkg::*;

	logic [HS_W-1:0] mem [DEPTH];
	logic [HS_W-1:0] rd_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// a one-pixel-wide frame reads the column being written in the same cycle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_s1 <= wr_data;
			end else begin
				rd_s1 <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_s1;

endmodule

`default_nettype wire

@@ hw/rtl/sg5_norm.sv @@
`default_nettype none

module sg5_norm (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  sg5_pkg::acc_item_t  in_item,
	output logic                out_valid,
	output sg5_pkg::result_t    out_item
);
	import sg5_pkg::*;

	logic              valid_s4;
	logic              last_s4;
	logic [PROD_W-1:0] prod_s4;
	logic [Q_W-1:0]    quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s4 <= in_item.last;
			prod_s4 <= PROD_W'(in_item.acc) * PROD_W'(RECIP);
		end
	end

	always_comb begin
		quot          = prod_s4[PROD_W-1:RECIP_SHIFT];
		out_item.last = last_s4;
		if (quot > Q_W'(PIX_MAX)) begin
			out_item.pix = PIX_W'(PIX_MAX);
		end else begin
			out_item.pix = quot[PIX_W-1:0];
		end
	end

	assign out_valid = valid_s4;

endmodule

`default_nettype wire

@@ hw/rtl/separable_gaussian_5x5_filter_core.sv @@
// 5x5 Gaussian blur (taps 1,4,7,4,1 each way) over a raster pixel stream.
// Input channel: in_valid/in_stall with operation and pixel. operation 0 is a
// frame pixel, 1 a drain tick; drain ticks inside the frame are consumed and
// dropped, and once the frame is complete any item counts as a drain tick.
// Output channel: out_valid/out_stall with filtered_pixel and last_of_frame.
// Output pixel (y,x) is produced by stream position y*width + x + 2*width + 2,
// so 2*width+2 drain ticks follow each frame; after last_of_frame the next
// item starts a new frame.
// One item per clock sustained while in_stall is low. A producing item passes
// the window register, line cells, vertical sum, reciprocal multiply, then a
// two-entry output buffer on its way to out_valid. in_stall rises only when
// the output buffer holds two results; the whole pipe then holds still until
// the receiver takes one. Configuration: cfg_valid/cfg_ready (always ready),
// cfg_index selects frame width or frame height; a write restarts the frame
// position. The user is to see it written only while idle; the block does
// not enforce this. Reset restores 640x480 and an empty pipe; the line stores
// are not cleared, rows above the frame are masked instead.
`default_nettype none

module separable_gaussian_5x5_filter_core #(
	parameter int MAX_WIDTH = sg5_pkg::MAX_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           operation,
	input  logic [sg5_pkg::PIX_W-1:0]      pixel,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [sg5_pkg::PIX_W-1:0]      filtered_pixel,
	output logic                           last_of_frame,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sg5_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sg5_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sg5_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int XW = WW + 1;
	localparam logic [1:0] LEAD_FULL = 2'd2;
	localparam int FIRST_OUT_ROW = 2;
	localparam int FIFO_DEPTH = 2;

	// configuration
	logic [WIDTH_REG_W-1:0]  width_raw_q;
	logic [HEIGHT_REG_W-1:0] height_raw_q;
	logic [WW-1:0]           w_eff;
	logic [ROW_W-1:0]        h_eff;
	logic                    cfg_take;
	logic                    cfg_hit;

	// stream position
	logic [ROW_W-1:0] in_row_q;
	logic [CW-1:0]    in_col_q;
	logic [1:0]       lead_q;
	logic [ROW_W-1:0] s_row_q;
	logic [CW-1:0]    s_col_q;
	logic [PIX_W-1:0] pwin_q [N_LINES];

	logic             adv;
	logic             in_take;
	logic             in_frame;
	logic             step;
	logic             has_s;
	logic             in_col_end;
	logic             s_col_end;
	logic             s_out;
	logic             s_last;
	logic             row_blank;
	logic [XW-1:0]    sx;
	logic [PIX_W-1:0] new_pix;
	logic [N_HTAPS-1:0] hmask;
	logic [PIX_W-1:0] win_m [N_HTAPS];
	logic [N_LINES-1:0] vmask;

	// pipeline
	logic               valid_s1;
	logic [PIX_W-1:0]   win_s1 [N_HTAPS];
	logic [CW-1:0]      sc_s1;
	logic               out_s1;
	logic               last_s1;
	logic [N_LINES-1:0] vmask_s1;
	logic [HS_W-1:0]    hs_s1;
	logic [HS_W-1:0]    cell_in [N_LINES];
	logic [HS_W-1:0]    line_rd [N_LINES];

	logic               valid_s2;
	logic               last_s2;
	logic [HS_W-1:0]    hs_s2;
	logic [HS_W-1:0]    vrow_s2 [N_LINES];
	logic [ACC_W-1:0]   acc_sum;

	logic               valid_s3;
	acc_item_t          acc_s3;

	logic               res_valid;
	result_t            res;

	// output buffer
	result_t fifo_q [FIFO_DEPTH];
	logic    wr_ptr_q;
	logic    rd_ptr_q;
	logic [1:0] cnt_q;
	logic    push;
	logic    pop;

	// ---------------------------------------------------------------- config
	assign cfg_ready = 1'b1;
	assign cfg_take  = cfg_valid && cfg_ready;
	assign cfg_hit   = cfg_take &&
		((cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_raw_q  <= WIDTH_REG_W'(WIDTH_RESET);
			height_raw_q <= HEIGHT_REG_W'(HEIGHT_RESET);
		end else if (cfg_take) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  width_raw_q  <= cfg_data[WIDTH_REG_W-1:0];
				REG_FRAME_HEIGHT: height_raw_q <= cfg_data[HEIGHT_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_raw_q == '0) begin
			w_eff = WW'(1);
		end else if (int'(width_raw_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_raw_q);
		end
		if (height_raw_q == '0) begin
			h_eff = ROW_W'(1);
		end else if (height_raw_q > HEIGHT_REG_W'(MAX_HEIGHT)) begin
			h_eff = ROW_W'(MAX_HEIGHT);
		end else begin
			h_eff = ROW_W'(height_raw_q);
		end
	end

	// ---------------------------------------------------------------- stage 0
	assign adv      = (cnt_q != 2'(FIFO_DEPTH));
	assign in_stall = !adv;
	assign in_take  = in_valid && !in_stall;

	always_comb begin
		in_frame   = in_row_q < h_eff;
		step       = in_take && !(in_frame && (operation == OP_DRAIN));
		new_pix    = in_frame ? pixel : '0;
		has_s      = (lead_q == LEAD_FULL);
		in_col_end = (XW'(in_col_q) + XW'(1)) == XW'(w_eff);
		sx         = XW'(s_col_q);
		s_col_end  = (sx + XW'(1)) == XW'(w_eff);
		s_out      = s_row_q >= ROW_W'(FIRST_OUT_ROW);
		s_last     = s_col_end && (s_row_q > h_eff);
		row_blank  = s_row_q >= h_eff;

		// neighbours left or right of the row edge count as zero
		hmask[0] = sx >= XW'(2);
		hmask[1] = sx >= XW'(1);
		hmask[2] = 1'b1;
		hmask[3] = (sx + XW'(1)) < XW'(w_eff);
		hmask[4] = (sx + XW'(2)) < XW'(w_eff);

		for (int j = 0; j < N_HTAPS - 1; j++) begin
			win_m[j] = (hmask[j] && !row_blank) ? pwin_q[j] : '0;
		end
		win_m[N_HTAPS-1] = (hmask[N_HTAPS-1] && !row_blank) ? new_pix : '0;

		// cell k holds row s_row-1-k; rows above the frame are masked
		for (int k = 0; k < N_LINES; k++) begin
			vmask[k] = s_row_q > ROW_W'(k);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q <= '0;
			in_col_q <= '0;
			lead_q   <= '0;
			s_row_q  <= '0;
			s_col_q  <= '0;
		end else if (cfg_hit || (step && has_s && s_last)) begin
			in_row_q <= '0;
			in_col_q <= '0;
			lead_q   <= '0;
			s_row_q  <= '0;
			s_col_q  <= '0;
		end else if (step) begin
			if (in_col_end) begin
				in_col_q <= '0;
				in_row_q <= in_row_q + ROW_W'(1);
			end else begin
				in_col_q <= in_col_q + CW'(1);
			end
			if (has_s) begin
				if (s_col_end) begin
					s_col_q <= '0;
					s_row_q <= s_row_q + ROW_W'(1);
				end else begin
					s_col_q <= s_col_q + CW'(1);
				end
			end else begin
				lead_q <= lead_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			for (int j = 0; j < N_LINES - 1; j++) begin
				pwin_q[j] <= pwin_q[j+1];
			end
			pwin_q[N_LINES-1] <= new_pix;
		end
	end

	// ---------------------------------------------------------------- stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= step && has_s;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			win_s1   <= win_m;
			sc_s1    <= s_col_q;
			out_s1   <= s_out;
			last_s1  <= s_last;
			vmask_s1 <= vmask;
		end
	end

	always_comb begin
		hs_s1 = HS_W'(win_s1[0]) + (HS_W'(win_s1[1]) << 2)
			+ (HS_W'(win_s1[2]) << 3) - HS_W'(win_s1[2])
			+ (HS_W'(win_s1[3]) << 2) + HS_W'(win_s1[4]);
		cell_in[0] = hs_s1;
		for (int k = 1; k < N_LINES; k++) begin
			cell_in[k] = line_rd[k-1];
		end
	end

	// each cell passes the row it held on to its neighbour as it takes a new one
	for (genvar k = 0; k < N_LINES; k++) begin : g_line
		sg5_line_cell #(
			.DEPTH(MAX_WIDTH)
		) u_cell (
			.clk    (clk),
			.rd_en  (adv),
			.rd_addr(s_col_q),
			.rd_data(line_rd[k]),
			.wr_en  (adv && valid_s1),
			.wr_addr(sc_s1),
			.wr_data(cell_in[k])
		);
	end

	// ---------------------------------------------------------------- stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1 && out_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s2 <= last_s1;
			hs_s2   <= hs_s1;
			for (int k = 0; k < N_LINES; k++) begin
				vrow_s2[k] <= vmask_s1[k] ? line_rd[k] : '0;
			end
		end
	end

	assign acc_sum = ACC_W'(hs_s2) + (ACC_W'(vrow_s2[0]) << 2)
		+ (ACC_W'(vrow_s2[1]) << 3) - ACC_W'(vrow_s2[1])
		+ (ACC_W'(vrow_s2[2]) << 2) + ACC_W'(vrow_s2[3])
		+ ACC_W'(ROUND_BIAS);

	// ---------------------------------------------------------------- stage 3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			acc_s3.last <= last_s2;
			acc_s3.acc  <= acc_sum;
		end
	end

	sg5_norm u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (valid_s3),
		.in_item  (acc_s3),
		.out_valid(res_valid),
		.out_item (res)
	);

	// ---------------------------------------------------------------- output
	assign push = adv && res_valid;
	assign pop  = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= res;
		end
	end

	assign out_valid      = (cnt_q != '0);
	assign filtered_pixel = fifo_q[rd_ptr_q].pix;
	assign last_of_frame  = fifo_q[rd_ptr_q].last;

endmodule

`default_nettype wire

@@ verif/tb_separable_gaussian_5x5_filter_core.sv @@
`timescale 1ns / 1ps

module tb_separable_gaussian_5x5_filter_core;
	import sg5_pkg::*;

	localparam int unsigned GAUSS_TAPS [5] = '{1, 4, 7, 4, 1};
	localparam int unsigned BLUR_DIVISOR   = 289;
	localparam int unsigned SETTLE_CYCLES  = 12;
	localparam int unsigned STUCK_LIMIT    = 5000;
	localparam int unsigned RANDOM_ITEMS   = 900;

	// Streaming blur predictor: mirrors the block's positions and line stores,
	// queues one expected pixel per producing transfer.
	class blur_scoreboard;
		int unsigned width_reg;
		int unsigned height_reg;
		bit [HS_W-1:0] row_sums [N_LINES][MAX_WIDTH_DEF];
		bit [PIX_W-1:0] window [4];
		int unsigned in_row, in_col, out_row, out_col;
		result_t expected_blur [$];
		int unsigned mismatches;

		function new();
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			window = '{default: '0};
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			in_row = 0;
			in_col = 0;
			out_row = 0;
			out_col = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_FRAME_WIDTH: width_reg = data[WIDTH_REG_W-1:0];
				REG_FRAME_HEIGHT: height_reg = data[HEIGHT_REG_W-1:0];
				default: return;
			endcase
			restart();
		endfunction

		function void note_item(logic op, logic [PIX_W-1:0] pix);
			int unsigned w, h, p, s, srow, scol, hsum, acc, q;
			int col, row, j;
			bit [PIX_W-1:0] taps_in [5];
			bit [PIX_W-1:0] v;
			bit last;
			w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg);
			h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
			p = in_row * w + in_col;
			v = '0;
			if (p < w * h) begin
				// drain ticks inside the frame are dropped outright
				if (op_t'(op) == OP_DRAIN)
					return;
				v = pix;
			end
			for (j = 0; j < 4; j++)
				taps_in[j] = window[j];
			taps_in[4] = v;
			for (j = 0; j < 3; j++)
				window[j] = window[j+1];
			window[3] = v;
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
			end
			if (p < 2)
				return;
			s = p - 2;
			srow = s / w;
			scol = s % w;
			hsum = 0;
			for (j = 0; j < 5; j++) begin
				col = int'(scol) + j - 2;
				if (col >= 0 && col < int'(w))
					hsum += GAUSS_TAPS[j] * taps_in[j];
			end
			if (srow >= h)
				hsum = 0;
			if (srow >= 2) begin
				acc = hsum;
				for (j = 0; j < 4; j++) begin
					row = int'(srow) - 4 + j;
					if (row >= 0 && row < int'(h))
						acc += GAUSS_TAPS[j] * row_sums[row % N_LINES][scol];
				end
				q = (acc + ROUND_BIAS) / BLUR_DIVISOR;
				if (q > PIX_MAX)
					q = PIX_MAX;
				last = (out_row + 1 >= h) && (out_col + 1 >= w);
				expected_blur.push_back('{last: last, pix: q[PIX_W-1:0]});
				out_col++;
				if (out_col >= w) begin
					out_col = 0;
					out_row++;
				end
				if (last)
					restart();
			end
			row_sums[srow % N_LINES][scol] = hsum[HS_W-1:0];
		endfunction

		function void flag(string msg);
			if (mismatches < 10)
				$display("%0t: %s", $time, msg);
			mismatches++;
		endfunction

		function void check_blurred(logic [PIX_W-1:0] pix, logic last);
			result_t want;
			if (expected_blur.size() == 0) begin
				flag($sformatf("result with nothing pending: pixel %0d last %0b", pix, last));
				return;
			end
			want = expected_blur.pop_front();
			if (pix !== want.pix)
				flag($sformatf("filtered_pixel mismatch: expected %0d, got %0d", want.pix, pix));
			if (last !== want.last)
				flag($sformatf("last_of_frame mismatch: expected %0b, got %0b", want.last, last));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic operation = 1'b0;
	logic [PIX_W-1:0] pixel = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [PIX_W-1:0] filtered_pixel;
	logic last_of_frame;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_reg_t cfg_index = REG_FRAME_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	blur_scoreboard sb;
	bit steady = 1'b0;
	int unsigned stall_hold = 0;
	int unsigned stuck_cycles = 0;
	int unsigned random_items = 0;

	separable_gaussian_5x5_filter_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.pixel(pixel),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.filtered_pixel(filtered_pixel),
		.last_of_frame(last_of_frame),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// mostly short idles, the odd long one
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_hold = 0;
		end else if (steady) begin
			out_stall <= 1'b0;
		end else if (stall_hold > 0) begin
			stall_hold--;
		end else begin
			out_stall <= ($urandom_range(0, 2) == 0);
			stall_hold = idle_len();
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (out_valid && !out_stall)
				sb.check_blurred(filtered_pixel, last_of_frame);
			if (in_valid && !in_stall)
				sb.note_item(operation, pixel);
		end
	end

	initial begin
		while (stuck_cycles < STUCK_LIMIT)
			@(posedge clk);
		$display("Regression FAIL");
		$finish;
	end

	task automatic send_item(op_t op, logic [PIX_W-1:0] pix);
		int unsigned gap;
		gap = steady ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		pixel <= pix;
		do @(posedge clk); while (in_stall);
	endtask

	// hold the sender until every pending result has been taken
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.expected_blur.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_frame(int unsigned w_reg, int unsigned h_reg, bit reconfig, bit cut);
		int unsigned ew, eh, n_pix, stop_at, k, r;
		logic [CFG_DATA_W-1:0] wdata;
		logic [PIX_W-1:0] v;
		ew = (w_reg == 0) ? 1 : ((w_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w_reg);
		eh = (h_reg == 0) ? 1 : ((h_reg > MAX_HEIGHT) ? MAX_HEIGHT : h_reg);
		n_pix = ew * eh;
		stop_at = n_pix + 2 * ew + 2;
		if (cut)
			stop_at = $urandom_range(1, stop_at - 1);
		if (reconfig) begin
			settle();
			wdata = CFG_DATA_W'(w_reg[WIDTH_REG_W-1:0]);
			wdata[CFG_DATA_W-1] = $urandom_range(0, 1);   // above the width field
			write_reg(REG_FRAME_WIDTH, wdata);
			write_reg(REG_FRAME_HEIGHT, h_reg[HEIGHT_REG_W-1:0]);
		end
		for (k = 0; k < stop_at; k++) begin
			if ($urandom_range(0, 299) == 0)
				settle();
			r = $urandom_range(0, 99);
			v = (r < 10) ? 8'd0 : ((r < 20) ? 8'd255 : 8'($urandom_range(0, 255)));
			if (k < n_pix) begin
				if ($urandom_range(0, 19) == 0)
					send_item(OP_DRAIN, 8'($urandom_range(0, 255)));
				send_item(OP_PIXEL, v);
			end else if ($urandom_range(0, 3) == 0) begin
				send_item(OP_PIXEL, v);
			end else begin
				send_item(OP_DRAIN, v);
			end
			random_items++;
		end
	endtask

	initial begin
		int unsigned r, w_reg, h_reg;
		bit cut, prev_cut, reconfig;
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset size: a few transfers, abandoned long before any output
		send_item(OP_PIXEL, 8'd255);
		send_item(OP_DRAIN, 8'd0);
		send_item(OP_PIXEL, 8'd0);
		send_item(OP_PIXEL, 8'h5a);

		// 3x2 frame with a drain tick mid-frame and a pixel after the frame
		settle();
		write_reg(REG_FRAME_WIDTH, 13'd3);
		write_reg(REG_FRAME_HEIGHT, 13'd2);
		send_item(OP_PIXEL, 8'd255);
		send_item(OP_PIXEL, 8'd0);
		send_item(OP_DRAIN, 8'd77);
		send_item(OP_PIXEL, 8'd255);
		send_item(OP_PIXEL, 8'd128);
		send_item(OP_PIXEL, 8'd1);
		send_item(OP_PIXEL, 8'd254);
		send_item(OP_DRAIN, 8'd0);
		send_item(OP_PIXEL, 8'haa);
		repeat (6) send_item(OP_DRAIN, 8'd0);

		// zero width and height act as a single pixel
		settle();
		write_reg(REG_FRAME_WIDTH, 13'h1000);
		write_reg(REG_FRAME_HEIGHT, 13'd0);
		send_item(OP_PIXEL, 8'd255);
		send_item(OP_PIXEL, 8'h33);
		repeat (3) send_item(OP_DRAIN, 8'd0);

		prev_cut = 1'b1;
		w_reg = 1;
		h_reg = 1;
		while (random_items < RANDOM_ITEMS) begin
			cut = ($urandom_range(0, 99) < 15);
			reconfig = prev_cut || ($urandom_range(0, 3) != 0);
			steady <= ($urandom_range(0, 4) == 0);
			if (reconfig) begin
				r = $urandom_range(0, 99);
				w_reg = (r < 5) ? 0 : ((r < 60) ? $urandom_range(1, 6) :
					((r < 90) ? $urandom_range(7, 24) : $urandom_range(25, 40)));
				r = $urandom_range(0, 99);
				h_reg = (r < 5) ? 0 : ((r < 65) ? $urandom_range(1, 5) : $urandom_range(6, 14));
			end
			run_frame(w_reg, h_reg, reconfig, cut);
			prev_cut = cut;
		end

		settle();
		if (sb.mismatches == 0 && sb.expected_blur.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ separable_gaussian_5x5_filter_core.f @@
hw/rtl/sg5_pkg.sv
hw/rtl/sg5_line_cell.sv
hw/rtl/sg5_norm.sv
hw/rtl/separable_gaussian_5x5_filter_core.sv
verif/tb_separable_gaussian_5x5_filter_core.sv
